>>> hdl/fte_pkg.sv
// Shared constants and calendar table for the timestamp-to-epoch converter.
`default_nettype none

package fte_pkg;

   // Input field widths
   localparam int unsigned YearWidth   = 16;
   localparam int unsigned CalWidth    = 8;
   localparam int unsigned FatWidth    = 16;
   localparam int unsigned EpochWidth  = 42;

   // Internal widths
   localparam int unsigned MonthWidth  = 4;
   localparam int unsigned DayWidth    = 5;
   localparam int unsigned HourWidth   = 5;
   localparam int unsigned MinWidth    = 6;
   localparam int unsigned TodWidth    = 17;   // seconds of day, up to 86399
   localparam int unsigned Q100Width   = 10;   // year / 100, up to 655
   localparam int unsigned ProdWidth   = 29;   // year * reciprocal
   localparam int unsigned ExtraWidth  = 14;   // leap days, month days and day offset
   localparam int unsigned DaysWidth   = 25;   // days since the epoch

   // Calendar constants
   localparam logic [YearWidth-1:0] EpochYear = 16'd1970;
   localparam logic [YearWidth-1:0] FatBaseYear = 16'd1980;
   localparam logic [15:0]          LeapsBeforeEpoch = 16'd477;  // leap years in 1..1969
   localparam int unsigned          SecPerDay = 86400;
   localparam int unsigned          SecPerHour = 3600;
   localparam int unsigned          SecPerMin = 60;

   // Floor reciprocal of 100: (y * Recip100) >> Recip100Shift is y/100 or one less
   localparam int unsigned Recip100      = 5242;
   localparam int unsigned Recip100Shift = 19;

   // Operation codes
   localparam logic OpFat = 1'b0;
   localparam logic OpCal = 1'b1;

   // Days in the months before the given month, non-leap year
   function automatic logic [8:0] days_before_month(input logic [MonthWidth-1:0] month);
      logic [8:0] d;
      case (month)
         4'd1:    d = 9'd0;
         4'd2:    d = 9'd31;
         4'd3:    d = 9'd59;
         4'd4:    d = 9'd90;
         4'd5:    d = 9'd120;
         4'd6:    d = 9'd151;
         4'd7:    d = 9'd181;
         4'd8:    d = 9'd212;
         4'd9:    d = 9'd243;
         4'd10:   d = 9'd273;
         4'd11:   d = 9'd304;
         4'd12:   d = 9'd334;
         default: d = 9'd0;
      endcase
      return d;
   endfunction

endpackage

`default_nettype wire

>>> hdl/fat_timestamp_to_epoch.sv
// Pipelined conversion of FAT or calendar timestamps to Unix seconds.
//
//  channel | direction | handshake             | payload
//  req     | in        | req_valid / req_ready | operation, fat_date, fat_time, cal_*
//  rsp     | out       | rsp_valid / rsp_ready | epoch_seconds (42 bits)
//
// Six register stages; one item is taken in every cycle while rsp keeps up.
// The stages are: field select and clamp, divide-by-100 correction, leap count,
// day count, day-to-second multiply, final add into the output register.
// The whole pipe advances together; a stall on rsp holds every stage and drops req_ready.
// Synchronous reset clears the valid bits only.
`default_nettype none

module fat_timestamp_to_epoch
   import fte_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,

   input  wire logic                   req_valid,
   output      logic                   req_ready,
   input  wire logic                   req_operation,
   input  wire logic [FatWidth-1:0]    req_fat_date,
   input  wire logic [FatWidth-1:0]    req_fat_time,
   input  wire logic [YearWidth-1:0]   req_cal_year,
   input  wire logic [CalWidth-1:0]    req_cal_month,
   input  wire logic [CalWidth-1:0]    req_cal_day,
   input  wire logic [CalWidth-1:0]    req_cal_hour,
   input  wire logic [CalWidth-1:0]    req_cal_minute,
   input  wire logic [CalWidth-1:0]    req_cal_second,

   output      logic                   rsp_valid,
   input  wire logic                   rsp_ready,
   output      logic [EpochWidth-1:0]  rsp_epoch_seconds
);

   // Pipe advance
   logic advance;
   assign advance   = !rsp_valid || rsp_ready;
   assign req_ready = advance;

   // Valid bits
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, vo_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         vo_ff <= 1'b0;
      end else if (advance) begin
         v1_ff <= req_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
         vo_ff <= v5_ff;
      end
   end

   assign rsp_valid = vo_ff;

   // Stage 1: select fields, clamp, start year / 100
   logic [CalWidth-1:0]   month_raw, day_raw, hour_raw, min_raw, sec_raw;
   logic [YearWidth-1:0]  s1_year_in;
   logic [MonthWidth-1:0] s1_month_in;
   logic [DayWidth-1:0]   s1_day_in;
   logic [HourWidth-1:0]  s1_hour_in;
   logic [MinWidth-1:0]   s1_min_in, s1_sec_in;
   logic                  s1_zero_in;
   logic [ProdWidth-1:0]  s1_prod_in;

   always_comb begin
      if (req_operation == OpCal) begin
         s1_year_in = req_cal_year;
         month_raw  = req_cal_month;
         day_raw    = req_cal_day;
         hour_raw   = req_cal_hour;
         min_raw    = req_cal_minute;
         sec_raw    = req_cal_second;
      end else begin
         s1_year_in = FatBaseYear + {9'd0, req_fat_date[15:9]};
         month_raw  = {4'd0, req_fat_date[8:5]};
         day_raw    = {3'd0, req_fat_date[4:0]};
         hour_raw   = {3'd0, req_fat_time[15:11]};
         min_raw    = {2'd0, req_fat_time[10:5]};
         sec_raw    = {2'd0, req_fat_time[4:0], 1'b0};
      end

      if (month_raw == 8'd0)       s1_month_in = 4'd1;
      else if (month_raw > 8'd12)  s1_month_in = 4'd12;
      else                         s1_month_in = month_raw[MonthWidth-1:0];

      if (day_raw == 8'd0)         s1_day_in = 5'd1;
      else if (day_raw > 8'd31)    s1_day_in = 5'd31;
      else                         s1_day_in = day_raw[DayWidth-1:0];

      s1_hour_in = (hour_raw > 8'd23) ? 5'd23 : hour_raw[HourWidth-1:0];
      s1_min_in  = (min_raw  > 8'd59) ? 6'd59 : min_raw[MinWidth-1:0];
      s1_sec_in  = (sec_raw  > 8'd59) ? 6'd59 : sec_raw[MinWidth-1:0];

      s1_zero_in = ((req_operation == OpFat) && (req_fat_date == 16'd0))
                   || (s1_year_in < EpochYear);
      s1_prod_in = {13'd0, s1_year_in} * ProdWidth'(Recip100);
   end

   logic [YearWidth-1:0]  s1_year_ff;
   logic [MonthWidth-1:0] s1_month_ff;
   logic [DayWidth-1:0]   s1_day_ff;
   logic [HourWidth-1:0]  s1_hour_ff;
   logic [MinWidth-1:0]   s1_min_ff, s1_sec_ff;
   logic                  s1_zero_ff;
   logic [ProdWidth-1:0]  s1_prod_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_year_ff  <= s1_year_in;
         s1_month_ff <= s1_month_in;
         s1_day_ff   <= s1_day_in;
         s1_hour_ff  <= s1_hour_in;
         s1_min_ff   <= s1_min_in;
         s1_sec_ff   <= s1_sec_in;
         s1_zero_ff  <= s1_zero_in;
         s1_prod_ff  <= s1_prod_in;
      end
   end

   // Stage 2: correct the quotient by one, time of day
   logic [Q100Width-1:0] q_raw;
   logic [TodWidth-1:0]  rem_raw;
   logic                 q_fix;
   logic [Q100Width-1:0] s2_q_in;
   logic                 s2_rnz_in;
   logic [TodWidth-1:0]  s2_tod_in;

   always_comb begin
      q_raw     = s1_prod_ff[ProdWidth-1:Recip100Shift];
      rem_raw   = {1'b0, s1_year_ff} - ({7'd0, q_raw} * 17'd100);
      q_fix     = (rem_raw >= 17'd100);
      s2_q_in   = q_raw + {{(Q100Width-1){1'b0}}, q_fix};
      s2_rnz_in = q_fix ? (rem_raw != 17'd100) : (rem_raw != 17'd0);
      s2_tod_in = ({12'd0, s1_hour_ff} * TodWidth'(SecPerHour))
                + ({11'd0, s1_min_ff} * TodWidth'(SecPerMin))
                + {11'd0, s1_sec_ff};
   end

   logic [YearWidth-1:0]  s2_year_ff;
   logic [MonthWidth-1:0] s2_month_ff;
   logic [DayWidth-1:0]   s2_day_ff;
   logic                  s2_zero_ff;
   logic [Q100Width-1:0]  s2_q_ff;
   logic                  s2_rnz_ff;
   logic [TodWidth-1:0]   s2_tod_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         s2_year_ff  <= s1_year_ff;
         s2_month_ff <= s1_month_ff;
         s2_day_ff   <= s1_day_ff;
         s2_zero_ff  <= s1_zero_ff;
         s2_q_ff     <= s2_q_in;
         s2_rnz_ff   <= s2_rnz_in;
         s2_tod_ff   <= s2_tod_in;
      end
   end

   // Stage 3: leap test, leap days since the epoch, days into the year
   logic                  is_leap;
   logic [15:0]           leaps;
   logic [ExtraWidth-1:0] month_days;
   logic [ExtraWidth-1:0] s3_extra_in;
   logic [YearWidth-1:0]  s3_yoff_in;

   always_comb begin
      is_leap = (s2_year_ff[1:0] == 2'd0) && (s2_rnz_ff || (s2_q_ff[1:0] == 2'd0));
      // leaps_upto(year - 1) - leaps_upto(1969)
      leaps = {2'd0, s2_year_ff[15:2]} - {6'd0, s2_q_ff} + {8'd0, s2_q_ff[9:2]}
            - {15'd0, is_leap} - LeapsBeforeEpoch;
      month_days = {5'd0, days_before_month(s2_month_ff)}
                 + {{(ExtraWidth-1){1'b0}}, (is_leap && (s2_month_ff > 4'd2))};
      s3_extra_in = leaps[ExtraWidth-1:0] + month_days
                  + {9'd0, s2_day_ff} - {{(ExtraWidth-1){1'b0}}, 1'b1};
      s3_yoff_in  = s2_year_ff - EpochYear;
   end

   logic [YearWidth-1:0]  s3_yoff_ff;
   logic [ExtraWidth-1:0] s3_extra_ff;
   logic                  s3_zero_ff;
   logic [TodWidth-1:0]   s3_tod_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         s3_yoff_ff  <= s3_yoff_in;
         s3_extra_ff <= s3_extra_in;
         s3_zero_ff  <= s2_zero_ff;
         s3_tod_ff   <= s2_tod_ff;
      end
   end

   // Stage 4: days since the epoch
   logic [DaysWidth-1:0] s4_days_in;
   assign s4_days_in = ({9'd0, s3_yoff_ff} * 25'd365) + {11'd0, s3_extra_ff};

   logic [DaysWidth-1:0] s4_days_ff;
   logic                 s4_zero_ff;
   logic [TodWidth-1:0]  s4_tod_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         s4_days_ff <= s4_days_in;
         s4_zero_ff <= s3_zero_ff;
         s4_tod_ff  <= s3_tod_ff;
      end
   end

   // Stage 5: days to seconds
   logic [EpochWidth-1:0] s5_secs_in;
   assign s5_secs_in = {17'd0, s4_days_ff} * EpochWidth'(SecPerDay);

   logic [EpochWidth-1:0] s5_secs_ff;
   logic                  s5_zero_ff;
   logic [TodWidth-1:0]   s5_tod_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         s5_secs_ff <= s5_secs_in;
         s5_zero_ff <= s4_zero_ff;
         s5_tod_ff  <= s4_tod_ff;
      end
   end

   // Stage 6: add time of day, force zero for empty or early dates
   logic [EpochWidth-1:0] epoch_in;
   logic [EpochWidth-1:0] epoch_ff;

   assign epoch_in = s5_zero_ff ? '0 : (s5_secs_ff + {25'd0, s5_tod_ff});

   always_ff @(posedge clock) begin
      if (advance) begin
         epoch_ff <= epoch_in;
      end
   end

   assign rsp_epoch_seconds = epoch_ff;

   // Assertions
   a_stall_blocks_req: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |-> !req_ready)
      else $error("req_ready high while result stalled");

   a_reset_empties: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   a_zero_result: assert property (@(posedge clock) disable iff (reset)
      (v5_ff && s5_zero_ff && advance) |=> (rsp_valid && (rsp_epoch_seconds == '0)))
      else $error("empty or early date gave a nonzero result");

   a_item_advances: assert property (@(posedge clock) disable iff (reset)
      (v3_ff && advance) |=> v4_ff)
      else $error("item lost between day-count stages");

endmodule

`default_nettype wire

>>> dv/testbench.sv
// Self-checking testbench for the FAT/calendar timestamp to Unix seconds converter.
`default_nettype none

module testbench;
   import fte_pkg::*;

   // One stimulus row: an input item, plus a typed-in result where it is obvious
   typedef struct packed {
      logic                  operation;
      logic [FatWidth-1:0]   fat_date;
      logic [FatWidth-1:0]   fat_time;
      logic [YearWidth-1:0]  cal_year;
      logic [CalWidth-1:0]   cal_month;
      logic [CalWidth-1:0]   cal_day;
      logic [CalWidth-1:0]   cal_hour;
      logic [CalWidth-1:0]   cal_minute;
      logic [CalWidth-1:0]   cal_second;
      logic                  known;
      logic [EpochWidth-1:0] epoch;
   } stamp_type;

   localparam int NumDirected = 23;
   localparam int NumRandom   = 1800;
   localparam int CalmTail    = 200;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   logic                  req_operation;
   logic [FatWidth-1:0]   req_fat_date;
   logic [FatWidth-1:0]   req_fat_time;
   logic [YearWidth-1:0]  req_cal_year;
   logic [CalWidth-1:0]   req_cal_month;
   logic [CalWidth-1:0]   req_cal_day;
   logic [CalWidth-1:0]   req_cal_hour;
   logic [CalWidth-1:0]   req_cal_minute;
   logic [CalWidth-1:0]   req_cal_second;
   logic                  rsp_valid;
   logic                  rsp_ready;
   logic [EpochWidth-1:0] rsp_epoch_seconds;

   logic [EpochWidth-1:0] expected_epochs [$];
   int                    failures = 0;
   int                    idle_pct = 0;   // percent chance of an idle burst, both sides

   // Directed rows: zero date, seconds doubling, clamps, leap days, year limits
   stamp_type directed_rows [NumDirected] = '{
      '{OpFat, 16'h0000, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1, 42'd0},
      '{OpFat, 16'h0021, 16'h0000, 16'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1, 42'd315532800},
      '{OpFat, 16'h0021, 16'h001D, 16'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1, 42'd315532858},
      '{OpFat, 16'h0021, 16'h001E, 16'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1, 42'd315532859},
      '{OpFat, 16'h0021, 16'h001F, 16'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1, 42'd315532859},
      '{OpFat, 16'hFFFF, 16'hFFFF, 16'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 42'd0},
      '{OpFat, 16'h0200, 16'h0000, 16'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 42'd0},
      '{OpFat, 16'h285D, 16'hBF7D, 16'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 42'd0},
      '{OpFat, 16'h025F, 16'h0000, 16'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 42'd0},
      '{OpFat, 16'h0001, 16'h0000, 16'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1, 42'd315532800},
      '{OpCal, 16'hFFFF, 16'hFFFF, 16'd1970, 8'd1, 8'd1, 8'd0, 8'd0, 8'd0, 1'b1, 42'd0},
      '{OpCal, 16'h0000, 16'h0000, 16'd1969, 8'd12, 8'd31, 8'd23, 8'd59, 8'd59, 1'b1, 42'd0},
      '{OpCal, 16'h0000, 16'h0000, 16'd0, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1, 42'd0},
      '{OpCal, 16'h0000, 16'h0000, 16'd1970, 8'd0, 8'd0, 8'hFF, 8'hFF, 8'hFF, 1'b1, 42'd86399},
      '{OpCal, 16'h0000, 16'h0000, 16'd1970, 8'd1, 8'd2, 8'd0, 8'd0, 8'd0, 1'b1, 42'd86400},
      '{OpCal, 16'h0000, 16'h0000, 16'd2000, 8'd1, 8'd1, 8'd0, 8'd0, 8'd0, 1'b1, 42'd946684800},
      '{OpCal, 16'h0000, 16'h0000, 16'd2038, 8'd1, 8'd19, 8'd3, 8'd14, 8'd8,
        1'b1, 42'd2147483648},
      '{OpCal, 16'h0000, 16'h0000, 16'd65535, 8'd12, 8'd31, 8'd23, 8'd59, 8'd59, 1'b0, 42'd0},
      '{OpCal, 16'h0000, 16'h0000, 16'd65535, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0, 42'd0},
      '{OpCal, 16'h0000, 16'h0000, 16'd2100, 8'd3, 8'd1, 8'd0, 8'd0, 8'd0, 1'b0, 42'd0},
      '{OpCal, 16'h0000, 16'h0000, 16'd2024, 8'd2, 8'd29, 8'd12, 8'd30, 8'd30, 1'b0, 42'd0},
      '{OpCal, 16'h0000, 16'h0000, 16'd2023, 8'd2, 8'd31, 8'd0, 8'd0, 8'd0, 1'b0, 42'd0},
      '{OpCal, 16'h0000, 16'h0000, 16'd1970, 8'd13, 8'd32, 8'd24, 8'd60, 8'd60, 1'b0, 42'd0}
   };

   fat_timestamp_to_epoch dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_operation     (req_operation),
      .req_fat_date      (req_fat_date),
      .req_fat_time      (req_fat_time),
      .req_cal_year      (req_cal_year),
      .req_cal_month     (req_cal_month),
      .req_cal_day       (req_cal_day),
      .req_cal_hour      (req_cal_hour),
      .req_cal_minute    (req_cal_minute),
      .req_cal_second    (req_cal_second),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_epoch_seconds (rsp_epoch_seconds)
   );

   // ---------------------------------------------------------------- predictor

   function automatic logic [63:0] leap_years_through(input logic [63:0] n);
      return n / 4 - n / 100 + n / 400;
   endfunction

   function automatic logic is_leap_year(input logic [63:0] y);
      return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
   endfunction

   function automatic logic [63:0] month_length(input int m);
      case (m)
         2:             return 64'd28;
         4, 6, 9, 11:   return 64'd30;
         default:       return 64'd31;
      endcase
   endfunction

   function automatic logic [EpochWidth-1:0] calendar_seconds(
      input logic [63:0] year, input logic [63:0] month, input logic [63:0] day,
      input logic [63:0] hour, input logic [63:0] minute, input logic [63:0] second);
      logic [63:0] days;
      logic [63:0] mo, dy, hr, mi, se;
      logic [63:0] total;
      if (year < EpochYear) return '0;
      mo = (month < 1) ? 64'd1 : (month > 12) ? 64'd12 : month;
      dy = (day < 1) ? 64'd1 : (day > 31) ? 64'd31 : day;
      hr = (hour > 23) ? 64'd23 : hour;
      mi = (minute > 59) ? 64'd59 : minute;
      se = (second > 59) ? 64'd59 : second;
      days = 365 * (year - EpochYear) + leap_years_through(year - 1)
             - leap_years_through(EpochYear - 1);
      // whole months before this one, February stretched in leap years
      for (int m = 1; m < mo; m++) begin
         days += month_length(m);
         if (m == 2 && is_leap_year(year)) days += 1;
      end
      days += dy - 1;
      total = days * SecPerDay + hr * SecPerHour + mi * SecPerMin + se;
      return total[EpochWidth-1:0];
   endfunction

   function automatic logic [EpochWidth-1:0] epoch_for_stamp(input stamp_type s);
      logic [63:0] fat_sec;
      if (s.operation == OpFat) begin
         if (s.fat_date == '0) return '0;
         fat_sec = 64'(s.fat_time[4:0]) * 2;
         return calendar_seconds(64'(FatBaseYear) + 64'(s.fat_date[15:9]),
                                 64'(s.fat_date[8:5]), 64'(s.fat_date[4:0]),
                                 64'(s.fat_time[15:11]), 64'(s.fat_time[10:5]), fat_sec);
      end
      return calendar_seconds(64'(s.cal_year), 64'(s.cal_month), 64'(s.cal_day),
                              64'(s.cal_hour), 64'(s.cal_minute), 64'(s.cal_second));
   endfunction

   // ---------------------------------------------------------------- clock and limit

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #2000000;
      $display("FAIL fat_timestamp_to_epoch");
      $finish;
   end

   // ---------------------------------------------------------------- request side

   // Optional idle burst, then hold the item until it is taken
   task automatic offer(input stamp_type s);
      if (idle_pct != 0 && $urandom_range(1, 100) <= idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_operation  <= s.operation;
      req_fat_date   <= s.fat_date;
      req_fat_time   <= s.fat_time;
      req_cal_year   <= s.cal_year;
      req_cal_month  <= s.cal_month;
      req_cal_day    <= s.cal_day;
      req_cal_hour   <= s.cal_hour;
      req_cal_minute <= s.cal_minute;
      req_cal_second <= s.cal_second;
      @(posedge clock);
      while (req_ready !== 1'b1) @(posedge clock);
      expected_epochs.push_back(s.known ? s.epoch : epoch_for_stamp(s));
   endtask

   initial begin
      stamp_type s;
      reset          <= 1'b1;
      req_valid      <= 1'b0;
      req_operation  <= OpFat;
      req_fat_date   <= '0;
      req_fat_time   <= '0;
      req_cal_year   <= '0;
      req_cal_month  <= '0;
      req_cal_day    <= '0;
      req_cal_hour   <= '0;
      req_cal_minute <= '0;
      req_cal_second <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table
      idle_pct = 20;
      for (int i = 0; i < NumDirected; i++) offer(directed_rows[i]);

      // random items, idling level redrawn every hundred items, zero in the calm tail
      for (int i = 0; i < NumRandom; i++) begin
         if (i >= NumRandom - CalmTail) begin
            idle_pct = 0;
         end else if (i % 100 == 0) begin
            case ($urandom_range(0, 3))
               0:       idle_pct = 0;
               1:       idle_pct = 10;
               2:       idle_pct = 30;
               default: idle_pct = 60;
            endcase
         end
         s.known      = 1'b0;
         s.epoch      = '0;
         s.fat_date   = 16'($urandom);
         s.fat_time   = 16'($urandom);
         s.cal_year   = 16'($urandom);
         s.cal_month  = 8'($urandom);
         s.cal_day    = 8'($urandom);
         s.cal_hour   = 8'($urandom);
         s.cal_minute = 8'($urandom);
         s.cal_second = 8'($urandom);
         case ($urandom_range(0, 9))
            // noise: every field raw
            0: s.operation = 1'($urandom);
            // well-formed FAT words, now and then raw or zero
            1, 2, 3, 4: begin
               s.operation = OpFat;
               s.fat_date  = {7'($urandom_range(0, 127)), 4'($urandom_range(1, 12)),
                              5'($urandom_range(1, 31))};
               s.fat_time  = {5'($urandom_range(0, 23)), 6'($urandom_range(0, 59)),
                              5'($urandom_range(0, 29))};
               if ($urandom_range(0, 7) == 0) s.fat_date = 16'($urandom);
               if ($urandom_range(0, 7) == 0) s.fat_time = 16'($urandom);
               if ($urandom_range(0, 19) == 0) s.fat_date = '0;
            end
            // calendar fields, mostly in range
            default: begin
               s.operation = OpCal;
               case ($urandom_range(0, 7))
                  0:       s.cal_year = 16'($urandom);
                  1:       s.cal_year = 16'($urandom_range(1900, 1969));
                  2:       s.cal_year = 16'($urandom_range(65000, 65535));
                  default: s.cal_year = 16'($urandom_range(1970, 2200));
               endcase
               if ($urandom_range(0, 5) != 0) s.cal_month  = 8'($urandom_range(1, 12));
               if ($urandom_range(0, 5) != 0) s.cal_day    = 8'($urandom_range(1, 31));
               if ($urandom_range(0, 5) != 0) s.cal_hour   = 8'($urandom_range(0, 23));
               if ($urandom_range(0, 5) != 0) s.cal_minute = 8'($urandom_range(0, 59));
               if ($urandom_range(0, 5) != 0) s.cal_second = 8'($urandom_range(0, 59));
            end
         endcase
         offer(s);
      end
      req_valid <= 1'b0;

      // drain, then let the pipe settle
      while (expected_epochs.size() != 0) @(posedge clock);
      repeat (12) @(posedge clock);
      @(negedge clock);
      if (failures == 0 && expected_epochs.size() == 0) begin
         $display("PASS fat_timestamp_to_epoch");
      end else begin
         $display("FAIL fat_timestamp_to_epoch");
      end
      $finish;
   end

   // ---------------------------------------------------------------- result side

   // Back-pressure in random bursts
   initial begin
      rsp_ready <= 1'b1;
      forever begin
         @(posedge clock);
         if (!reset && idle_pct != 0 && $urandom_range(1, 100) <= idle_pct) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clock);
            rsp_ready <= 1'b1;
         end
      end
   end

   // Compare each result taken with the oldest expected epoch
   always @(posedge clock) begin
      logic [EpochWidth-1:0] want;
      if (!reset && rsp_valid === 1'b1 && rsp_ready === 1'b1) begin
         if (expected_epochs.size() == 0) begin
            $error("epoch_seconds: expected none, actual %0d", rsp_epoch_seconds);
            failures++;
         end else begin
            want = expected_epochs.pop_front();
            if (rsp_epoch_seconds !== want) begin
               $error("epoch_seconds: expected %0d, actual %0d", want, rsp_epoch_seconds);
               failures++;
            end
         end
      end
   end

endmodule

`default_nettype wire

>>> filelist.f
hdl/fte_pkg.sv
hdl/fat_timestamp_to_epoch.sv
dv/testbench.sv
